@@ sv/dhcpoc_pkg.sv @@
// ----------------------------------------------------------------------------
// dhcpoc_pkg
// Types, codes and the known-option table for the DHCPv4 options checker.
// ----------------------------------------------------------------------------
package dhcpoc_pkg;

	typedef enum logic [1:0] {
		PH_CODE = 2'd0,
		PH_LEN  = 2'd1,
		PH_BODY = 2'd2,
		PH_HALT = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_SHORT = 3'd1,
		ST_ALIGN = 3'd2,
		ST_FIXED = 3'd3,
		ST_TRUNC = 3'd4,
		ST_END   = 3'd5,
		ST_NOEND = 3'd6
	} status_t;

	typedef enum logic [7:0] {
		CFG_SERVER_EN   = 8'd0,
		CFG_EXTENDED_EN = 8'd1
	} cfg_reg_t;

	localparam logic [7:0] CODE_PAD = 8'd0;
	localparam logic [7:0] CODE_END = 8'd255;
	localparam int unsigned CfgIndexWidth = 8;
	localparam int unsigned CfgDataWidth  = 8;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] option_code;
		logic [7:0] option_length;
		logic       known_code;
		status_t    status;
		logic       list_done;
	} out_item_t;

	typedef struct packed {
		logic       known;
		logic [2:0] fixed_len;   // 0 means no fixed length
		logic [1:0] align_mask;  // low length bits that must be zero
		logic [2:0] min_item;    // code + length + payload
	} rule_t;

	function automatic rule_t lookup_rule(input logic [7:0] code, input logic srv_en,
		input logic ext_en);
		rule_t r;
		r = '{known: 1'b1, fixed_len: 3'd0, align_mask: 2'b00, min_item: 3'd3};
		case (code)
			8'd1:    r = '{1'b1, 3'd4, 2'b00, 3'd6};
			8'd3:    r = '{1'b1, 3'd0, 2'b11, 3'd6};
			8'd5:    r = '{srv_en, 3'd0, 2'b11, 3'd6};
			8'd6:    r = '{1'b1, 3'd0, 2'b11, 3'd6};
			8'd12:   r = '{1'b1, 3'd0, 2'b00, 3'd3};
			8'd15:   r = '{1'b1, 3'd0, 2'b00, 3'd3};
			8'd28:   r = '{1'b1, 3'd4, 2'b11, 3'd6};
			8'd50:   r = '{1'b1, 3'd4, 2'b11, 3'd6};
			8'd51:   r = '{1'b1, 3'd4, 2'b11, 3'd6};
			8'd53:   r = '{1'b1, 3'd1, 2'b00, 3'd3};
			8'd54:   r = '{1'b1, 3'd4, 2'b11, 3'd6};
			8'd55:   r = '{1'b1, 3'd0, 2'b00, 3'd3};
			8'd57:   r = '{1'b1, 3'd2, 2'b01, 3'd4};
			8'd58:   r = '{1'b1, 3'd4, 2'b11, 3'd6};
			8'd59:   r = '{1'b1, 3'd4, 2'b11, 3'd6};
			8'd61:   r = '{1'b1, 3'd0, 2'b00, 3'd4};
			8'd120:  r = '{1'b1, 3'd0, 2'b00, 3'd3};
			8'd66:   r = '{ext_en, 3'd0, 2'b00, 3'd3};
			8'd52:   r = '{ext_en, 3'd0, 2'b00, 3'd3};
			8'd150:  r = '{ext_en, 3'd0, 2'b00, 3'd3};
			default: r = '{1'b0, 3'd0, 2'b00, 3'd0};
		endcase
		return r;
	endfunction

	function automatic status_t check_option(input rule_t r, input logic [7:0] len);
		status_t st;
		if (!r.known) begin
			st = ST_OK;
		end else if (({1'b0, len} + 9'd2) < {6'b0, r.min_item}) begin
			st = ST_SHORT;
		end else if ((len[1:0] & r.align_mask) != 2'b00) begin
			st = ST_ALIGN;
		end else if ((r.fixed_len != 3'd0) && (len != {5'b0, r.fixed_len})) begin
			st = ST_FIXED;
		end else begin
			st = ST_OK;
		end
		return st;
	endfunction

endpackage

@@ sv/dhcp_option_list_checker_unit.sv @@
// ----------------------------------------------------------------------------
// dhcp_option_list_checker_unit
// Walks a DHCPv4 options field byte by byte and reports each option's status.
// ----------------------------------------------------------------------------
// Path: an accepted byte sits in the input register, then its result moves to the
// result register.
// Throughput: one byte per cycle; a byte waits only while a result is held
// in the result register and not taken, and the byte in the input register also gives one.
// Reset: parser expects a code, both enables set, no beat pending.
module dhcp_option_list_checker_unit (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     in_valid,
	output logic                                     in_ready,
	input  dhcpoc_pkg::in_item_t                     in_item,
	output logic                                     out_valid,
	input  logic                                     out_ready,
	output dhcpoc_pkg::out_item_t                    out_item,
	input  logic                                     cfg_valid,
	output logic                                     cfg_ready,
	input  logic [dhcpoc_pkg::CfgIndexWidth-1:0]     cfg_index,
	input  logic [dhcpoc_pkg::CfgDataWidth-1:0]      cfg_data
);

	dhcpoc_pkg::in_item_t  item_s1;
	logic                  valid_s1;
	dhcpoc_pkg::out_item_t out_q;
	logic                  out_valid_q;

	dhcpoc_pkg::phase_t    phase_q, phase_d;
	logic [7:0]            code_q, code_d;
	logic [7:0]            len_q, len_d;
	logic [7:0]            rem_q, rem_d;
	logic                  srv_en_q, ext_en_q;

	logic                  advance;
	logic                  res_valid;
	dhcpoc_pkg::out_item_t res;

	logic [7:0]            b;
	logic                  last;
	logic [7:0]            rem_dec;
	logic [7:0]            fin_len;
	dhcpoc_pkg::rule_t     rule_cur, rule_new;
	dhcpoc_pkg::status_t   fin_chk;
	logic                  fin_now;

	assign b        = item_s1.data_byte;
	assign last     = item_s1.last_byte;
	assign rem_dec  = rem_q - 8'd1;
	assign rule_cur = dhcpoc_pkg::lookup_rule(code_q, srv_en_q, ext_en_q);
	assign rule_new = dhcpoc_pkg::lookup_rule(b, srv_en_q, ext_en_q);
	assign fin_len  = (phase_q == dhcpoc_pkg::PH_LEN) ? b : len_q;
	assign fin_chk  = dhcpoc_pkg::check_option(rule_cur, fin_len);
	// option closes on a zero length byte or on its last payload byte
	assign fin_now  = ((phase_q == dhcpoc_pkg::PH_LEN) && (b == 8'd0)) ||
	                  ((phase_q == dhcpoc_pkg::PH_BODY) && (rem_dec == 8'd0));

	// result for the byte in the input register
	always_comb begin
		res_valid = 1'b0;
		res = '{option_code: code_q, option_length: fin_len, known_code: rule_cur.known,
		        status: dhcpoc_pkg::ST_TRUNC, list_done: 1'b1};
		case (phase_q)
			dhcpoc_pkg::PH_CODE: begin
				res.option_code   = b;
				res.option_length = 8'd0;
				res.known_code    = 1'b0;
				if (b == dhcpoc_pkg::CODE_PAD) begin
					res_valid  = last;
					res.status = dhcpoc_pkg::ST_NOEND;
				end else if (b == dhcpoc_pkg::CODE_END) begin
					res_valid  = 1'b1;
					res.status = dhcpoc_pkg::ST_END;
				end else begin
					res_valid      = last;
					res.known_code = rule_new.known;
				end
			end
			dhcpoc_pkg::PH_LEN, dhcpoc_pkg::PH_BODY: begin
				if (fin_now) begin
					res_valid = 1'b1;
					if (fin_chk != dhcpoc_pkg::ST_OK) begin
						res.status = fin_chk;
					end else if (last) begin
						res.status = dhcpoc_pkg::ST_NOEND;
					end else begin
						res.status    = dhcpoc_pkg::ST_OK;
						res.list_done = 1'b0;
					end
				end else begin
					res_valid = last;
				end
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// parser next state
	always_comb begin
		phase_d = phase_q;
		code_d  = code_q;
		len_d   = len_q;
		rem_d   = rem_q;
		case (phase_q)
			dhcpoc_pkg::PH_CODE: begin
				if (b == dhcpoc_pkg::CODE_PAD) begin
					phase_d = dhcpoc_pkg::PH_CODE;
				end else if (b == dhcpoc_pkg::CODE_END) begin
					phase_d = last ? dhcpoc_pkg::PH_CODE : dhcpoc_pkg::PH_HALT;
				end else begin
					code_d  = b;
					len_d   = 8'd0;
					rem_d   = 8'd0;
					phase_d = last ? dhcpoc_pkg::PH_CODE : dhcpoc_pkg::PH_LEN;
				end
			end
			dhcpoc_pkg::PH_LEN, dhcpoc_pkg::PH_BODY: begin
				if (phase_q == dhcpoc_pkg::PH_LEN) begin
					len_d = b;
					rem_d = b;
				end else begin
					rem_d = rem_dec;
				end
				if (last) begin
					phase_d = dhcpoc_pkg::PH_CODE;
				end else if (fin_now) begin
					phase_d = (fin_chk != dhcpoc_pkg::ST_OK) ? dhcpoc_pkg::PH_HALT
					                                         : dhcpoc_pkg::PH_CODE;
				end else begin
					phase_d = dhcpoc_pkg::PH_BODY;
				end
			end
			default: begin
				phase_d = last ? dhcpoc_pkg::PH_CODE : dhcpoc_pkg::PH_HALT;
			end
		endcase
	end

	// hold the input beat only when its result has nowhere to go
	assign advance   = valid_s1 && (!res_valid || !out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || advance;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dhcpoc_pkg::PH_CODE;
			code_q  <= 8'd0;
			len_q   <= 8'd0;
			rem_q   <= 8'd0;
		end else if (advance) begin
			phase_q <= phase_d;
			code_q  <= code_d;
			len_q   <= len_d;
			rem_q   <= rem_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			out_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			srv_en_q <= 1'b1;
			ext_en_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				dhcpoc_pkg::CFG_SERVER_EN:   srv_en_q <= cfg_data[0];
				dhcpoc_pkg::CFG_EXTENDED_EN: ext_en_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	a_end_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.status == dhcpoc_pkg::ST_END) |-> out_q.list_done)
		else $error("end marker result without list_done");

	a_stop_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ((out_q.status == dhcpoc_pkg::ST_TRUNC) ||
		(out_q.status == dhcpoc_pkg::ST_NOEND)) |-> out_q.list_done)
		else $error("truncated or missing end result without list_done");

	a_rearm: assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.last_byte |=> (phase_q == dhcpoc_pkg::PH_CODE))
		else $error("parser did not rearm after last byte");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |-> !in_ready && out_valid_q)
		else $error("input beat held without a pending result");

	a_ok_open: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.status == dhcpoc_pkg::ST_OK) |-> !out_q.list_done)
		else $error("ok result closed the list");

endmodule

@@ bench/dhcp_option_list_checker_unit_checker.sv @@
// ----------------------------------------------------------------------------
// dhcp_option_report_checker
// Watches the byte, result and register channels of the options checker,
// walks each accepted byte through its own option parser and compares every
// result beat field by field against the oldest report it predicted.
// ----------------------------------------------------------------------------
module dhcp_option_report_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic                                 in_ready,
	input  dhcpoc_pkg::in_item_t                 in_item,
	input  logic                                 out_valid,
	input  logic                                 out_ready,
	input  dhcpoc_pkg::out_item_t                out_item,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic [dhcpoc_pkg::CfgIndexWidth-1:0] cfg_index,
	input  logic [dhcpoc_pkg::CfgDataWidth-1:0]  cfg_data,
	output int                                   errors,
	output int                                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic       known;
		logic [7:0] fixed_len;
		logic [7:0] align;
		logic [7:0] min_item;
	} opt_limits_t;

	dhcpoc_pkg::phase_t    phase = dhcpoc_pkg::PH_CODE;
	logic [7:0]            cur_code = 8'd0;
	logic [7:0]            cur_len = 8'd0;
	logic [7:0]            remain = 8'd0;
	logic                  srv_en = 1'b1;
	logic                  ext_en = 1'b1;
	int                    mismatches = 0;
	dhcpoc_pkg::out_item_t awaited_reports[$];

	function automatic opt_limits_t limits_for(input logic [7:0] code, input logic srv,
		input logic ext);
		opt_limits_t lim;
		lim = {1'b1, 8'd0, 8'd1, 8'd3};
		case (code)
			8'd1: lim = {1'b1, 8'd4, 8'd1, 8'd6};
			8'd3, 8'd6: lim = {1'b1, 8'd0, 8'd4, 8'd6};
			8'd5: lim = {srv, 8'd0, 8'd4, 8'd6};
			8'd12, 8'd15, 8'd55, 8'd120: ;
			8'd28, 8'd50, 8'd51, 8'd54, 8'd58, 8'd59: lim = {1'b1, 8'd4, 8'd4, 8'd6};
			8'd53: lim = {1'b1, 8'd1, 8'd1, 8'd3};
			8'd57: lim = {1'b1, 8'd2, 8'd2, 8'd4};
			8'd61: lim = {1'b1, 8'd0, 8'd1, 8'd4};
			8'd52, 8'd66, 8'd150: lim.known = ext;
			default: lim.known = 1'b0;
		endcase
		return lim;
	endfunction

	// Minimum size first, then alignment, then any fixed payload length.
	function automatic dhcpoc_pkg::status_t judge_option(input opt_limits_t lim,
		input logic [7:0] len);
		int size;
		size = int'(len) + 2;
		if (!lim.known)
			return dhcpoc_pkg::ST_OK;
		if (size < int'(lim.min_item))
			return dhcpoc_pkg::ST_SHORT;
		if ((int'(len) % int'(lim.align)) != 0)
			return dhcpoc_pkg::ST_ALIGN;
		if (lim.fixed_len != 8'd0 && len != lim.fixed_len)
			return dhcpoc_pkg::ST_FIXED;
		return dhcpoc_pkg::ST_OK;
	endfunction

	task automatic push_report(input logic [7:0] code, input logic [7:0] len,
		input logic known, input dhcpoc_pkg::status_t st, input logic done);
		dhcpoc_pkg::out_item_t rep;
		rep.option_code   = code;
		rep.option_length = len;
		rep.known_code    = known;
		rep.status        = st;
		rep.list_done     = done;
		awaited_reports.push_back(rep);
	endtask

	task automatic close_option(input logic lst);
		opt_limits_t         lim;
		dhcpoc_pkg::status_t st;
		logic                done;
		lim  = limits_for(cur_code, srv_en, ext_en);
		st   = judge_option(lim, cur_len);
		done = (st != dhcpoc_pkg::ST_OK) || lst;
		if (st == dhcpoc_pkg::ST_OK && lst)
			st = dhcpoc_pkg::ST_NOEND;
		push_report(cur_code, cur_len, lim.known, st, done);
		phase = (done && !lst) ? dhcpoc_pkg::PH_HALT : dhcpoc_pkg::PH_CODE;
	endtask

	task automatic absorb_byte(input dhcpoc_pkg::in_item_t beat);
		logic [7:0]  b;
		logic        lst;
		opt_limits_t lim;
		b   = beat.data_byte;
		lst = beat.last_byte;
		case (phase)
			dhcpoc_pkg::PH_CODE: begin
				if (b == dhcpoc_pkg::CODE_PAD) begin
					if (lst)
						push_report(dhcpoc_pkg::CODE_PAD, 8'd0, 1'b0, dhcpoc_pkg::ST_NOEND,
							1'b1);
				end else if (b == dhcpoc_pkg::CODE_END) begin
					push_report(dhcpoc_pkg::CODE_END, 8'd0, 1'b0, dhcpoc_pkg::ST_END, 1'b1);
					phase = lst ? dhcpoc_pkg::PH_CODE : dhcpoc_pkg::PH_HALT;
				end else begin
					cur_code = b;
					cur_len  = 8'd0;
					remain   = 8'd0;
					if (lst) begin
						lim = limits_for(b, srv_en, ext_en);
						push_report(b, 8'd0, lim.known, dhcpoc_pkg::ST_TRUNC, 1'b1);
					end else begin
						phase = dhcpoc_pkg::PH_LEN;
					end
				end
			end
			dhcpoc_pkg::PH_LEN: begin
				cur_len = b;
				remain  = b;
				if (b == 8'd0) begin
					close_option(lst);
				end else if (lst) begin
					lim = limits_for(cur_code, srv_en, ext_en);
					push_report(cur_code, b, lim.known, dhcpoc_pkg::ST_TRUNC, 1'b1);
					phase = dhcpoc_pkg::PH_CODE;
				end else begin
					phase = dhcpoc_pkg::PH_BODY;
				end
			end
			dhcpoc_pkg::PH_BODY: begin
				remain = remain - 8'd1;
				if (remain == 8'd0) begin
					close_option(lst);
				end else if (lst) begin
					lim = limits_for(cur_code, srv_en, ext_en);
					push_report(cur_code, cur_len, lim.known, dhcpoc_pkg::ST_TRUNC, 1'b1);
					phase = dhcpoc_pkg::PH_CODE;
				end
			end
			default: begin
				// halted: drop bytes until the message ends
				if (lst)
					phase = dhcpoc_pkg::PH_CODE;
			end
		endcase
	endtask

	task automatic compare_report(input dhcpoc_pkg::out_item_t got);
		dhcpoc_pkg::out_item_t want;
		if (awaited_reports.size() == 0) begin
			$error("unexpected result beat: option_code %0d status %0d",
				got.option_code, got.status);
			mismatches++;
		end else begin
			want = awaited_reports.pop_front();
			if (got.option_code !== want.option_code) begin
				$error("option_code: expected %0d, got %0d", want.option_code, got.option_code);
				mismatches++;
			end
			if (got.option_length !== want.option_length) begin
				$error("option_length: expected %0d, got %0d", want.option_length,
					got.option_length);
				mismatches++;
			end
			if (got.known_code !== want.known_code) begin
				$error("known_code: expected %0d, got %0d", want.known_code, got.known_code);
				mismatches++;
			end
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
			if (got.list_done !== want.list_done) begin
				$error("list_done: expected %0d, got %0d", want.list_done, got.list_done);
				mismatches++;
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase    = dhcpoc_pkg::PH_CODE;
			cur_code = 8'd0;
			cur_len  = 8'd0;
			remain   = 8'd0;
			srv_en   = 1'b1;
			ext_en   = 1'b1;
			awaited_reports.delete();
			errors  <= mismatches;
			pending <= 0;
		end else begin
			if (out_valid && out_ready)
				compare_report(out_item);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == dhcpoc_pkg::CFG_SERVER_EN)
					srv_en = cfg_data[0];
				else if (cfg_index == dhcpoc_pkg::CFG_EXTENDED_EN)
					ext_en = cfg_data[0];
			end
			if (in_valid && in_ready)
				absorb_byte(in_item);
			errors  <= mismatches;
			pending <= awaited_reports.size();
		end
	end

endmodule

@@ bench/dhcp_option_list_checker_unit_tb.sv @@
// ----------------------------------------------------------------------------
// dhcp_option_list_checker_unit_tb
// Feeds DHCPv4 options fields byte by byte: a directed set of end, pad,
// truncation and check-failure messages, then random messages (mostly valid
// option lists, some cut short, some noise) under several enable settings
// and idling mixes. The report checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module dhcp_option_list_checker_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	logic                                 clk = 1'b0;
	logic                                 arst_n;
	logic                                 in_valid;
	logic                                 in_ready;
	dhcpoc_pkg::in_item_t                 in_item;
	logic                                 out_valid;
	logic                                 out_ready = 1'b0;
	dhcpoc_pkg::out_item_t                out_item;
	logic                                 cfg_valid;
	logic                                 cfg_ready;
	logic [dhcpoc_pkg::CfgIndexWidth-1:0] cfg_index;
	logic [dhcpoc_pkg::CfgDataWidth-1:0]  cfg_data;
	int                                   errors;
	int                                   pending;
	int                                   send_idle_pct = 0;
	int                                   recv_stall_pct = 0;
	int                                   beats_sent = 0;

	logic [7:0] catalog [0:19] = '{8'd1, 8'd3, 8'd5, 8'd6, 8'd12, 8'd15, 8'd28, 8'd50,
		8'd51, 8'd53, 8'd54, 8'd55, 8'd57, 8'd58, 8'd59, 8'd61, 8'd120, 8'd66, 8'd52, 8'd150};

	dhcp_option_list_checker_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	dhcp_option_report_checker checker_i (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.errors    (errors),
		.pending   (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_stall_pct);

	// Valid stays high after a beat; the next beat replaces it, an idle gap or an explicit drop lowers it.
	task automatic send_beat(input logic [7:0] b, input logic lst);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item  <= '{data_byte: b, last_byte: lst};
		do @(posedge clk); while (!in_ready);
		beats_sent++;
	endtask

	task automatic write_reg(input logic [7:0] idx, input logic en);
		logic [7:0] word;
		word      = 8'($urandom_range(255));
		word[0]   = en;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= word;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Wait out every expected report, then the pipeline for bytes without one.
	task automatic settle();
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reconfigure(input logic srv, input logic ext);
		in_valid <= 1'b0;
		settle();
		write_reg(dhcpoc_pkg::CFG_SERVER_EN, srv);
		write_reg(dhcpoc_pkg::CFG_EXTENDED_EN, ext);
		write_reg(8'($urandom_range(2, 255)), 1'($urandom_range(1)));
		cfg_valid <= 1'b0;
	endtask

	function automatic int option_len(input logic [7:0] code);
		int roll;
		roll = $urandom_range(99);
		if (roll < 1)
			return $urandom_range(200, 255);
		if (roll < 20)
			return $urandom_range(9);
		case (code)
			8'd1, 8'd28, 8'd50, 8'd51, 8'd54, 8'd58, 8'd59: return 4;
			8'd53: return 1;
			8'd57: return 2;
			8'd3, 8'd5, 8'd6: return 4 * $urandom_range(1, 3);
			8'd61: return $urandom_range(2, 8);
			default: return $urandom_range(1, 8);
		endcase
	endfunction

	task automatic send_message();
		logic [7:0] msg[$];
		logic [7:0] code;
		int         kind;
		int         len;
		int         cut;
		int         k;
		kind = $urandom_range(99);
		if (kind < 10) begin
			repeat ($urandom_range(1, 8)) msg.push_back(8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(1, 4)) begin
				if ($urandom_range(99) < 15) begin
					msg.push_back(dhcpoc_pkg::CODE_PAD);
				end else begin
					if ($urandom_range(99) < 70)
						code = catalog[5'($urandom_range(19))];
					else
						code = 8'($urandom_range(1, 254));
					len = option_len(code);
					msg.push_back(code);
					msg.push_back(len[7:0]);
					repeat (len) msg.push_back(8'($urandom_range(255)));
				end
			end
			if ($urandom_range(99) < 80) begin
				msg.push_back(dhcpoc_pkg::CODE_END);
				repeat ($urandom_range(3)) msg.push_back(8'($urandom_range(255)));
			end
			// cut some messages short to exercise truncation
			if (kind >= 85) begin
				cut = $urandom_range(1, msg.size());
				while (msg.size() > cut) void'(msg.pop_back());
			end
		end
		for (k = 0; k < msg.size(); k++)
			send_beat(msg[k], k == msg.size() - 1);
	endtask

	task automatic run_phase(input int idle, input int stall, input logic srv,
		input logic ext, input int target);
		int start;
		reconfigure(srv, ext);
		send_idle_pct  = idle;
		recv_stall_pct = stall;
		start = beats_sent;
		while (beats_sent - start < target) send_message();
	endtask

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_item   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		reconfigure(1'b1, 1'b1);

		// pad, good option, end marker, then a halted byte that ends the message
		send_beat(dhcpoc_pkg::CODE_PAD, 1'b0);
		send_beat(8'd53, 1'b0);
		send_beat(8'd1, 1'b0);
		send_beat(8'h05, 1'b0);
		send_beat(dhcpoc_pkg::CODE_END, 1'b0);
		send_beat(8'hAA, 1'b1);
		// too short, completing on the last byte
		send_beat(8'd1, 1'b0);
		send_beat(8'd2, 1'b0);
		send_beat(8'h12, 1'b0);
		send_beat(8'h34, 1'b1);
		// pad on the last byte, end on the last byte
		send_beat(dhcpoc_pkg::CODE_PAD, 1'b1);
		send_beat(dhcpoc_pkg::CODE_END, 1'b1);
		// unknown code, empty payload, no end marker
		send_beat(8'd200, 1'b0);
		send_beat(8'd0, 1'b1);
		// truncated after the code, then on the length byte
		send_beat(8'd50, 1'b1);
		send_beat(8'd6, 1'b0);
		send_beat(8'd4, 1'b1);
		// misaligned, then a wrong fixed length that is cut short before its payload ends
		send_beat(8'd57, 1'b0);
		send_beat(8'd3, 1'b0);
		send_beat(8'h00, 1'b0);
		send_beat(8'hFF, 1'b0);
		send_beat(8'h80, 1'b1);
		send_beat(8'd53, 1'b0);
		send_beat(8'd2, 1'b0);
		send_beat(8'h01, 1'b1);

		run_phase(0, 0, 1'b0, 1'b0, 95);
		run_phase(81, 0, 1'b1, 1'b0, 95);
		run_phase(0, 81, 1'b0, 1'b1, 95);
		run_phase(29, 29, 1'b1, 1'b1, 95);

		in_valid <= 1'b0;
		settle();
		if (errors == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

@@ sim.f @@
sv/dhcpoc_pkg.sv
sv/dhcp_option_list_checker_unit.sv
bench/dhcp_option_list_checker_unit_checker.sv
bench/dhcp_option_list_checker_unit_tb.sv
